// ----- rtl/core/b64e_pkg.sv -----
// Shared types, constants and the sextet-to-character map for the Base64 encoder.
package b64e_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CharW = 7;
  localparam int unsigned SextW = 6;
  localparam int unsigned MaxChars = 4;
  localparam int unsigned CharIdxW = 2;

  localparam logic [CharW-1:0] PadChar = 7'd61;
  localparam logic [CharW-1:0] UpperA = 7'd65;
  localparam logic [CharW-1:0] LowerA = 7'd97;
  localparam logic [CharW-1:0] Digit0 = 7'd48;
  localparam logic [CharW-1:0] PlusChar = 7'd43;
  localparam logic [CharW-1:0] SlashChar = 7'd47;

  localparam logic [1:0] Phase0 = 2'd0;
  localparam logic [1:0] Phase1 = 2'd1;
  localparam logic [1:0] Phase2 = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             final_byte;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             end_of_text;
  } out_item_t;

  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [CharIdxW-1:0]            last_idx;
    logic                           eot;
  } char_cmd_t;

  function automatic logic [CharW-1:0] sextet_char(input logic [SextW-1:0] v);
    logic [CharW-1:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      return UpperA + v7;
    end else if (v < 6'd52) begin
      return LowerA + v7 - 7'd26;
    end else if (v < 6'd62) begin
      return Digit0 + v7 - 7'd52;
    end else if (v == 6'd62) begin
      return PlusChar;
    end else begin
      return SlashChar;
    end
  endfunction

endpackage

// ----- rtl/core/b64e_front.sv -----
// Input side: takes bytes, tracks the group phase and builds character commands.
module b64e_front import b64e_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  in_data_i,
  input  logic      fifo_full_i,
  output logic      full,
  output logic      cmd_push_o,
  output char_cmd_t cmd_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic       accept;
  logic [ByteW-1:0] b;
  logic       fin;

  assign full = fifo_full_i;
  assign accept = push && !fifo_full_i;
  assign cmd_push_o = accept;
  assign b = in_data_i.data_byte;
  assign fin = in_data_i.final_byte;

  always_comb begin
    cmd_o = '0;
    cmd_o.eot = fin;
    phase_d = phase_q;
    carry_d = carry_q;
    case (phase_q)
      Phase1: begin
        cmd_o.chars[0] = sextet_char({carry_q[1:0], b[7:4]});
        cmd_o.chars[1] = sextet_char({b[3:0], 2'b00});
        cmd_o.chars[2] = PadChar;
        cmd_o.last_idx = fin ? 2'd2 : 2'd0;
        carry_d = b[3:0];
        phase_d = Phase2;
      end
      Phase2: begin
        cmd_o.chars[0] = sextet_char({carry_q, b[7:6]});
        cmd_o.chars[1] = sextet_char(b[5:0]);
        cmd_o.last_idx = 2'd1;
        carry_d = 4'd0;
        phase_d = Phase0;
      end
      default: begin
        cmd_o.chars[0] = sextet_char(b[7:2]);
        cmd_o.chars[1] = sextet_char({b[1:0], 4'b0000});
        cmd_o.chars[2] = PadChar;
        cmd_o.chars[3] = PadChar;
        cmd_o.last_idx = fin ? 2'd3 : 2'd0;
        carry_d = {2'b00, b[1:0]};
        phase_d = Phase1;
      end
    endcase
    if (fin) begin
      phase_d = Phase0;
      carry_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= Phase0;
      carry_q <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

// ----- rtl/core/b64e_cmd_fifo.sv -----
// Short command queue between the input side and the character serializer.
module b64e_cmd_fifo import b64e_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  char_cmd_t wr_data_i,
  input  logic      rd_i,
  output char_cmd_t rd_data_o,
  output logic      full_o,
  output logic      valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  char_cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic do_wr, do_rd;

  assign full_o = (cnt_q == DepthCnt);
  assign valid_o = (cnt_q != '0);
  assign do_wr = wr_i && !full_o;
  assign do_rd = rd_i && valid_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/b64e_back.sv -----
// Output side: walks each command one character per cycle into the result register while the receiver keeps popping.
module b64e_back import b64e_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  char_cmd_t cmd_i,
  output logic      cmd_pop_o,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_data_o
);

  logic                out_valid_q;
  out_item_t           out_q;
  logic [CharIdxW-1:0] idx_q;
  logic                take;
  logic                load;
  logic                at_last;

  assign take = pop && out_valid_q;
  assign load = cmd_valid_i && (!out_valid_q || take);
  assign at_last = (idx_q == cmd_i.last_idx);
  assign cmd_pop_o = load && at_last;
  assign empty = !out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_char <= cmd_i.chars[idx_q];
      out_q.end_of_text <= cmd_i.eot && at_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q <= at_last ? '0 : idx_q + 1'b1;
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/base64_stream_encoder.sv -----
// Top level of the Base64 stream encoder.
// Encodes a byte stream into standard Base64 characters with '=' padding, one
// byte per input transfer and one character per output transfer; end_of_text
// marks the last character of each message. A byte turns into one to four
// characters; the serializer delivers one character per cycle while the
// receiver keeps popping, and sets the pace. Mid-stream a byte yields at most
// two characters (the third byte of a group yields two), so a full group of
// three bytes yields four; a final byte yields up to four with its pads.
// Up to CmdDepth bytes may wait between the two sides before full rises.
module base64_stream_encoder import b64e_pkg::*; #(
  parameter int unsigned CmdDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data_o
);

  logic      fifo_full;
  logic      cmd_push;
  char_cmd_t cmd_wr;
  logic      cmd_pop;
  logic      cmd_valid;
  char_cmd_t cmd_rd;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_data_i   (in_data_i),
    .fifo_full_i (fifo_full),
    .full        (full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_wr)
  );

  b64e_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_push),
    .wr_data_i (cmd_wr),
    .rd_i      (cmd_pop),
    .rd_data_o (cmd_rd),
    .full_o    (fifo_full),
    .valid_o   (cmd_valid)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/b64e_checker.sv -----
// Port-level checks for the Base64 stream encoder and their bind.
module b64e_checker import b64e_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input in_item_t  in_data_i,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data_o
);

  logic [CharW-1:0] c;
  logic             legal_char;

  assign c = out_data_o.out_char;
  assign legal_char = (c >= 7'd65 && c <= 7'd90) || (c >= 7'd97 && c <= 7'd122) ||
                      (c >= 7'd48 && c <= 7'd57) || (c == PlusChar) ||
                      (c == SlashChar) || (c == PadChar);

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result changed while waiting");

  a_legal_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> legal_char)
    else $error("result is not a Base64 character");

  a_pad_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && c == PadChar && !out_data_o.end_of_text) |=>
      (!empty && out_data_o.out_char == PadChar && out_data_o.end_of_text))
    else $error("first pad not followed by closing pad");

  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not cleared by reset");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && full) |=> (push && $stable(in_data_i)))
    else $error("offered byte changed while stalled");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .in_data_i  (in_data_i),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);

// ----- verif/tb.sv -----
// Self-checking testbench for base64_stream_encoder: byte messages in, checked characters out.
`timescale 1ns / 1ps

module tb;
  import b64e_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int ItemTarget = 165;
  localparam logic [8*64-1:0] B64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_data_i = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_data_o;

  in_item_t  pending_bytes[$];
  out_item_t chars_due[$];
  out_item_t want;

  logic [1:0] enc_phase = Phase0;
  logic [3:0] enc_carry = 4'd0;

  int errors = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int chars_seen = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  base64_stream_encoder dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_data_i (in_data_i),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data_o)
  );

  function automatic logic [CharW-1:0] b64_char(input logic [SextW-1:0] v);
    logic [7:0] code;
    code = B64Alphabet[8*(63 - int'(v)) +: 8];
    return code[CharW-1:0];
  endfunction

  function automatic void add_char(input logic [CharW-1:0] c, input logic last);
    out_item_t o;
    o.out_char = c;
    o.end_of_text = last;
    chars_due = {chars_due, o};
  endfunction

  function automatic void encode_byte(input in_item_t it);
    logic [7:0] b;
    logic       fin;
    b = it.data_byte;
    fin = it.final_byte;
    case (enc_phase)
      Phase1: begin
        add_char(b64_char({enc_carry[1:0], b[7:4]}), 1'b0);
        enc_carry = b[3:0];
        enc_phase = Phase2;
        if (fin) begin
          add_char(b64_char({enc_carry, 2'b00}), 1'b0);
          add_char(PadChar, 1'b1);
        end
      end
      Phase2: begin
        add_char(b64_char({enc_carry, b[7:6]}), 1'b0);
        add_char(b64_char(b[5:0]), fin);
        enc_carry = 4'd0;
        enc_phase = Phase0;
      end
      default: begin
        add_char(b64_char(b[7:2]), 1'b0);
        enc_carry = {2'b00, b[1:0]};
        enc_phase = Phase1;
        if (fin) begin
          add_char(b64_char({enc_carry[1:0], 4'b0000}), 1'b0);
          add_char(PadChar, 1'b0);
          add_char(PadChar, 1'b1);
        end
      end
    endcase
    if (fin) begin
      enc_phase = Phase0;
      enc_carry = 4'd0;
    end
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic fin);
    in_item_t it;
    it.data_byte = b;
    it.final_byte = fin;
    pending_bytes = {pending_bytes, it};
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at char %0d: %s", chars_seen, msg);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sender: hold the offered byte until it transfers.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (push && !full) begin
        encode_byte(in_data_i);
        bytes_sent++;
      end
      if (!push || !full) begin
        if (pending_bytes.size() != 0 &&
            ((bytes_sent >= 60 && bytes_sent < 120) || $urandom_range(99) >= 7)) begin
          push <= 1'b1;
          in_data_i <= pending_bytes.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Hold-off counter: one long receiver stall once traffic is under way.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!stall_done && chars_seen >= 40) begin
        stall_done <= 1'b1;
        stall_left <= 80;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // Receiver: check each transfer, hold off while the stall counter runs.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        chars_seen++;
        if (chars_due.size() == 0) begin
          report_mismatch($sformatf("unexpected char %0d eot %0b",
                                    out_data_o.out_char, out_data_o.end_of_text));
        end else begin
          want = chars_due.pop_front();
          if (out_data_o.out_char !== want.out_char) begin
            report_mismatch($sformatf("out_char %0d, want %0d",
                                      out_data_o.out_char, want.out_char));
          end
          if (out_data_o.end_of_text !== want.end_of_text) begin
            report_mismatch($sformatf("end_of_text %0b, want %0b",
                                      out_data_o.end_of_text, want.end_of_text));
          end
        end
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
      end else begin
        pop <= (chars_seen >= 100 && chars_seen < 180) || $urandom_range(99) >= 7;
      end
    end
  end

  initial begin
    int         msg_len;
    logic [7:0] rnd_byte;

    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h4D, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h6E, 1'b1);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'hBE, 1'b0);
    queue_byte(8'h10, 1'b0);
    queue_byte(8'h83, 1'b0);
    queue_byte(8'h10, 1'b1);

    while (pending_bytes.size() < ItemTarget) begin
      msg_len = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(9, 1);
      for (int k = 0; k < msg_len; k++) begin
        case ($urandom_range(7))
          0:       rnd_byte = 8'h00;
          1:       rnd_byte = 8'hFF;
          default: rnd_byte = 8'($urandom);
        endcase
        queue_byte(rnd_byte, k == msg_len - 1);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || push) @(posedge clk_i);
    while (chars_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/b64e_pkg.sv
rtl/core/b64e_front.sv
rtl/core/b64e_cmd_fifo.sv
rtl/core/b64e_back.sv
rtl/core/base64_stream_encoder.sv
rtl/core/b64e_checker.sv
verif/tb.sv
